FILE: rtl/core/mtg_pkg.sv
package mtg_pkg;

    localparam int TABLE_DEPTH_DEF   = 624;
    localparam int MIDDLE_OFFSET_DEF = 397;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam logic [31:0] SEED_RESET  = 32'd5489;
    localparam logic [31:0] MATRIX_A    = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B    = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C    = 32'hEFC6_0000;
    localparam logic [31:0] INIT_MULT   = 32'd1812433253;

    localparam logic [1:0] ACT_RESEED = 2'd0;
    localparam logic [1:0] ACT_DRAW   = 2'd1;
    localparam logic [1:0] ACT_RANGE  = 2'd2;

    localparam logic [1:0] CLS_FIXED  = 2'd0;
    localparam logic [1:0] CLS_RESEED = 2'd1;
    localparam logic [1:0] CLS_DRAW   = 2'd2;
    localparam logic [1:0] CLS_RANGE  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] range_low;
        logic [31:0] range_high;
    } command_t;

    typedef struct packed {
        logic [31:0] value;
        logic        status;
    } result_t;

    typedef struct packed {
        logic [1:0]  cls;
        logic [31:0] base;
        logic [31:0] span;
        logic        status;
    } job_t;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

FILE: rtl/core/mersenne_twister_generator_top.sv
// MT19937 generator. A command is taken when start is high and busy is low; busy rises only
// while the command queue (QUEUE_DEPTH entries) is full. Every command gives one result, shown
// on result for a single cycle with done high; the receiver cannot stall it, so sample it then.
// A reseed writes word 0 as the command is taken from the queue, and each further word
// needs a multiply step and then an add-and-write step; a raw draw makes three reads
// through the one read port of the table RAM; a range draw forms the remainder one bit
// per cycle, except for a full 32-bit span, which is returned unreduced; bad ranges, a zero
// upper bound, unused action codes and draws before the first reseed are answered straight
// from the idle state. The seed register may be written at any time the block is idle and
// takes effect at the next reseed.
module mersenne_twister_generator_top #(
    parameter int TABLE_DEPTH   = mtg_pkg::TABLE_DEPTH_DEF,
    parameter int MIDDLE_OFFSET = mtg_pkg::MIDDLE_OFFSET_DEF,
    parameter int QUEUE_DEPTH   = mtg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mtg_pkg::command_t command,
    output logic              done,
    output mtg_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);

    logic          push;
    mtg_pkg::job_t push_job;
    mtg_pkg::job_t head_job;
    logic          pop;
    logic          queue_full;
    logic          queue_empty;
    logic [31:0]   seed;

    mtg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job),
        .seed       (seed)
    );

    mtg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    mtg_back #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MIDDLE_OFFSET (MIDDLE_OFFSET)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_job    (head_job),
        .pop         (pop),
        .seed        (seed),
        .done        (done),
        .result      (result)
    );

endmodule

FILE: rtl/core/mtg_ram.sv
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = mtg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mtg_queue.sv
module mtg_queue #(
    parameter int DEPTH = mtg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mtg_pkg::job_t push_job,
    input  logic          pop,
    output mtg_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mtg_pkg::job_t  slot_reg [DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

FILE: rtl/core/mtg_front.sv
module mtg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mtg_pkg::command_t command,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data,
    input  logic              queue_full,
    output logic              push,
    output mtg_pkg::job_t     push_job,
    output logic [31:0]       seed
);

    logic [31:0] seed_reg;

    assign cfg_ready = 1'b1;
    assign busy      = queue_full;
    assign push      = start && !queue_full;
    assign seed      = seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= mtg_pkg::SEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    always_comb
    begin
        push_job.cls    = mtg_pkg::CLS_FIXED;
        push_job.base   = '0;
        push_job.span   = '0;
        push_job.status = 1'b0;
        case (command.action)
            mtg_pkg::ACT_RESEED:
            begin
                push_job.cls = mtg_pkg::CLS_RESEED;
            end
            mtg_pkg::ACT_DRAW:
            begin
                push_job.cls = mtg_pkg::CLS_DRAW;
            end
            mtg_pkg::ACT_RANGE:
            begin
                if (command.range_low > command.range_high)
                begin
                    push_job.base   = '1;
                    push_job.status = 1'b1;
                end
                else if (command.range_high == '0)
                begin
                    push_job.base = command.range_low;
                end
                else
                begin
                    push_job.cls  = mtg_pkg::CLS_RANGE;
                    push_job.base = command.range_low;
                    push_job.span = command.range_high - command.range_low + 32'd1;
                end
            end
            default:
            begin
                push_job.cls = mtg_pkg::CLS_FIXED;
            end
        endcase
    end

endmodule

FILE: rtl/core/mtg_back.sv
module mtg_back #(
    parameter int TABLE_DEPTH   = mtg_pkg::TABLE_DEPTH_DEF,
    parameter int MIDDLE_OFFSET = mtg_pkg::MIDDLE_OFFSET_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  mtg_pkg::job_t    head_job,
    output logic             pop,
    input  logic [31:0]      seed,
    output logic             done,
    output mtg_pkg::result_t result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SEED_MUL = 4'd1;
    localparam logic [3:0] S_SEED_ADD = 4'd2;
    localparam logic [3:0] S_RD_NEXT  = 4'd3;
    localparam logic [3:0] S_RD_FAR   = 4'd4;
    localparam logic [3:0] S_TWIST    = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_FIN      = 4'd7;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             seeded_reg, seeded_next;
    logic             done_reg, done_next;
    mtg_pkg::result_t result_reg, result_next;
    mtg_pkg::job_t    cur_reg, cur_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      prev_reg, prev_next;
    logic [31:0]      prod_reg, prod_next;
    logic             upper_reg, upper_next;
    logic [31:0]      xa_reg, xa_next;
    logic [31:0]      dvd_reg, dvd_next;
    logic [31:0]      rem_reg, rem_next;
    logic [4:0]       cnt_reg, cnt_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata;
    logic [IDX_W-1:0] raddr;
    logic [31:0]      rdata;

    logic [IDX_W-1:0] pos_inc;
    logic [IDX_W:0]   far_sum;
    logic [IDX_W-1:0] far_idx;
    logic [31:0]      twist_in;
    logic [31:0]      new_word;
    logic [31:0]      seed_word;
    logic [32:0]      trial;
    logic [32:0]      span_w;

    mtg_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign pos_inc   = (pos_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
    assign far_sum   = {1'b0, pos_reg} + (IDX_W + 1)'(MIDDLE_OFFSET);
    assign far_idx   = (far_sum >= (IDX_W + 1)'(TABLE_DEPTH))
                       ? IDX_W'(far_sum - (IDX_W + 1)'(TABLE_DEPTH))
                       : far_sum[IDX_W-1:0];
    assign twist_in  = {upper_reg, rdata[30:0]};
    assign new_word  = rdata ^ xa_reg;
    assign seed_word = prod_reg + 32'(idx_reg);
    assign trial     = {rem_reg, dvd_reg[31]};
    assign span_w    = {1'b0, cur_reg.span};

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        seeded_next = seeded_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        prev_next   = prev_reg;
        prod_next   = prod_reg;
        upper_next  = upper_reg;
        xa_next     = xa_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        pop         = 1'b0;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = new_word;
        raddr       = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop      = 1'b1;
                    cur_next = head_job;
                    case (head_job.cls)
                        mtg_pkg::CLS_RESEED:
                        begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata      = seed;
                            prev_next  = seed;
                            idx_next   = IDX_W'(1);
                            state_next = S_SEED_MUL;
                        end
                        mtg_pkg::CLS_DRAW, mtg_pkg::CLS_RANGE:
                        begin
                            if (seeded_reg)
                            begin
                                state_next = S_RD_NEXT;
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                result_next.status = 1'b0;
                                result_next.value  = (head_job.cls == mtg_pkg::CLS_RANGE)
                                                     ? head_job.base : '0;
                            end
                        end
                        default:
                        begin
                            done_next          = 1'b1;
                            result_next.value  = head_job.base;
                            result_next.status = head_job.status;
                        end
                    endcase
                end
            end
            S_SEED_MUL:
            begin
                prod_next  = mtg_pkg::INIT_MULT * (prev_reg ^ (prev_reg >> 30));
                state_next = S_SEED_ADD;
            end
            S_SEED_ADD:
            begin
                we        = 1'b1;
                waddr     = idx_reg;
                wdata     = seed_word;
                prev_next = seed_word;
                if (idx_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    pos_next    = '0;
                    seeded_next = 1'b1;
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SEED_MUL;
                end
            end
            S_RD_NEXT:
            begin
                raddr      = pos_inc;
                upper_next = rdata[31];
                state_next = S_RD_FAR;
            end
            S_RD_FAR:
            begin
                raddr      = far_idx;
                xa_next    = (twist_in >> 1) ^ (twist_in[0] ? mtg_pkg::MATRIX_A : '0);
                state_next = S_TWIST;
            end
            S_TWIST:
            begin
                we       = 1'b1;
                waddr    = pos_reg;
                wdata    = new_word;
                pos_next = pos_inc;
                if (cur_reg.cls == mtg_pkg::CLS_RANGE)
                begin
                    dvd_next   = mtg_pkg::temper(new_word);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    done_next          = 1'b1;
                    result_next.value  = mtg_pkg::temper(new_word);
                    result_next.status = 1'b0;
                    state_next         = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (cur_reg.span == '0)
                begin
                    done_next          = 1'b1;
                    result_next.value  = dvd_reg;
                    result_next.status = 1'b0;
                    state_next         = S_IDLE;
                end
                else
                begin
                    rem_next = (trial >= span_w) ? 32'(trial - span_w) : trial[31:0];
                    dvd_next = dvd_reg << 1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                done_next          = 1'b1;
                result_next.value  = cur_reg.base + rem_reg;
                result_next.status = 1'b0;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            seeded_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            seeded_reg <= seeded_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        cur_reg    <= cur_next;
        idx_reg    <= idx_next;
        prev_reg   <= prev_next;
        prod_reg   <= prod_next;
        upper_reg  <= upper_next;
        xa_reg     <= xa_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_pos_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < IDX_W'(TABLE_DEPTH))
        else $error("table position out of range");

    a_bad_range_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.value == '1))
        else $error("bad-range result without all-ones value");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE))
        else $error("job taken while busy");

    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (waddr < IDX_W'(TABLE_DEPTH)))
        else $error("table write out of range");

endmodule

FILE: sim/mersenne_twister_generator_top_test.sv
module mersenne_twister_generator_top_test;

    import mtg_pkg::*;

    localparam int          WORDS          = 624;
    localparam int          FAR_STEP       = 397;
    localparam logic [31:0] SEED_AT_RESET  = 32'd5489;
    localparam logic [31:0] SEED_STEP      = 32'd1812433253;
    localparam logic [31:0] TWIST_MATRIX   = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_MASK_B  = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_MASK_C  = 32'hEFC6_0000;
    localparam logic [1:0]  ACT_UNUSED     = 2'd3;
    localparam logic        STATUS_OK      = 1'b0;
    localparam logic        STATUS_BAD     = 1'b1;
    localparam bit          KNOWN          = 1'b1;
    localparam bit          PREDICT        = 1'b0;
    localparam int          IDLE_PERCENT   = 38;
    localparam int          TAIL_CYCLES    = 1300;
    localparam int unsigned RUN_LIMIT      = 5_000_000;
    localparam int          DIRECTED_COUNT = 20;

    typedef struct packed {
        command_t cmd;
        bit       typed;
        result_t  want;
    } vector_t;

    localparam vector_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // before any reseed
        {ACT_DRAW,   32'h0000_0000, 32'h0000_0000, KNOWN,   32'h0000_0000, STATUS_OK},
        {ACT_RANGE,  32'h0000_0005, 32'h0000_0009, KNOWN,   32'h0000_0005, STATUS_OK},
        {ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, KNOWN,   32'h0000_0000, STATUS_OK},
        {ACT_RANGE,  32'h0000_0009, 32'h0000_0005, KNOWN,   32'hFFFF_FFFF, STATUS_BAD},
        {ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KNOWN,   32'h0000_0000, STATUS_OK},
        {ACT_RESEED, 32'h0000_0000, 32'h0000_0000, KNOWN,   32'h0000_0000, STATUS_OK},
        {ACT_DRAW,   32'h0000_0000, 32'h0000_0000, PREDICT, 32'h0000_0000, STATUS_OK},
        {ACT_DRAW,   32'hFFFF_FFFF, 32'hFFFF_FFFF, PREDICT, 32'h0000_0000, STATUS_OK},
        {ACT_RANGE,  32'h0000_0000, 32'h0000_0000, KNOWN,   32'h0000_0000, STATUS_OK},
        {ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, PREDICT, 32'h0000_0000, STATUS_OK},
        {ACT_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, KNOWN,   32'hFFFF_FFFF, STATUS_OK},
        {ACT_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, KNOWN,   32'hFFFF_FFFF, STATUS_BAD},
        {ACT_RANGE,  32'h0000_0001, 32'h0000_0000, KNOWN,   32'hFFFF_FFFF, STATUS_BAD},
        {ACT_RANGE,  32'h0000_0000, 32'h0000_0001, PREDICT, 32'h0000_0000, STATUS_OK},
        {ACT_RANGE,  32'h0000_0001, 32'hFFFF_FFFF, PREDICT, 32'h0000_0000, STATUS_OK},
        {ACT_RANGE,  32'h7FFF_FFFF, 32'h8000_0000, PREDICT, 32'h0000_0000, STATUS_OK},
        {ACT_RANGE,  32'h1234_5678, 32'h1234_5678, KNOWN,   32'h1234_5678, STATUS_OK},
        {ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFFE, PREDICT, 32'h0000_0000, STATUS_OK},
        {ACT_RESEED, 32'hFFFF_FFFF, 32'h0000_0000, KNOWN,   32'h0000_0000, STATUS_OK},
        {ACT_DRAW,   32'h0000_0000, 32'h0000_0000, PREDICT, 32'h0000_0000, STATUS_OK}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    command_t    command   = '0;
    logic        done;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    logic [31:0] twist_words [WORDS];
    int unsigned twist_pos    = 0;
    bit          twist_seeded = 1'b0;
    logic [31:0] seed_shadow  = SEED_AT_RESET;

    result_t     pending_results [$];
    result_t     oldest_result;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    mersenne_twister_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void reseed_words(input logic [31:0] seed);
        logic [31:0] w;
        w = seed;
        twist_words[0] = w;
        for (int i = 1; i < WORDS; i++)
        begin
            w = SEED_STEP * (w ^ (w >> 30)) + i;
            twist_words[i] = w;
        end
        twist_pos    = 0;
        twist_seeded = 1'b1;
    endfunction

    function automatic logic [31:0] next_word();
        int unsigned here, nxt, ahead;
        logic [31:0] x, y;
        if (!twist_seeded)
            return 32'd0;
        here  = twist_pos;
        nxt   = (here + 1) % WORDS;
        ahead = (here + FAR_STEP) % WORDS;
        x = {twist_words[here][31], twist_words[nxt][30:0]};
        y = x >> 1;
        if (x[0])
            y = y ^ TWIST_MATRIX;
        x = twist_words[ahead] ^ y;
        twist_words[here] = x;
        twist_pos = nxt;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_MASK_B);
        y = y ^ ((y << 15) & TEMPER_MASK_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic result_t predict_result(input command_t c);
        result_t     r;
        logic [31:0] span, w;
        r = '0;
        case (c.action)
            ACT_RESEED: reseed_words(seed_shadow);
            ACT_DRAW:   r.value = next_word();
            ACT_RANGE:
            begin
                if (c.range_low > c.range_high)
                begin
                    r.value  = '1;
                    r.status = STATUS_BAD;
                end
                else if (c.range_high == 32'd0)
                    r.value = c.range_low;
                else
                begin
                    span = c.range_high - c.range_low + 32'd1;
                    w = next_word();
                    r.value = (span == 32'd0) ? w : c.range_low + (w % span);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic command_t random_command(input bit reseeds, input int draw_cut);
        command_t    c;
        int          pick;
        logic [31:0] a, b;
        c.range_low  = $urandom;
        c.range_high = $urandom;
        a = $urandom;
        b = $urandom;
        pick = $urandom_range(0, 99);
        if (reseeds && pick < 6)
            c.action = ACT_RESEED;
        else if (pick < 9)
            c.action = ACT_UNUSED;
        else if (pick < draw_cut)
            c.action = ACT_DRAW;
        else
        begin
            c.action = ACT_RANGE;
            case ($urandom_range(0, 9))
                0: ;
                1:
                begin
                    c.range_low  = (a > b) ? a : b;
                    c.range_high = (a > b) ? b : a;
                end
                2:
                begin
                    c.range_high = 32'd0;
                    if (a[0])
                        c.range_low = 32'd0;
                end
                3:
                begin
                    c.range_low  = 32'd0;
                    c.range_high = '1;
                end
                4: c.range_high = c.range_low;
                5, 6:
                begin
                    c.range_low  = a;
                    c.range_high = a + $urandom_range(0, 15);
                    if (c.range_high < a)
                        c.range_high = a;
                end
                7:
                begin
                    c.range_low  = $urandom_range(0, 1000);
                    c.range_high = c.range_low + ((32'd1 << $urandom_range(0, 31)) - 32'd1);
                    if (c.range_high < c.range_low)
                        c.range_high = '1;
                end
                default:
                begin
                    c.range_low  = (a > b) ? b : a;
                    c.range_high = (a > b) ? a : b;
                end
            endcase
        end
        return c;
    endfunction

    task automatic issue(input command_t c, input bit steady, input bit typed,
                         input result_t want);
        result_t got;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        command <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        got = predict_result(c);
        pending_results.push_back(typed ? want : got);
    endtask

    // drop start and hold until every result is back
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        @(negedge clk);
        while ($urandom_range(0, 99) < IDLE_PERCENT)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        seed_shadow = seed;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transfer, value %h status %b", $time,
                         result.value, result.status);
                mismatch_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (result.value !== oldest_result.value)
                begin
                    $display("%0t: value expected %h actual %h", $time,
                             oldest_result.value, result.value);
                    mismatch_count++;
                end
                if (result.status !== oldest_result.status)
                begin
                    $display("%0t: status expected %b actual %b", $time,
                             oldest_result.status, result.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        command_t    c;
        logic [31:0] seed;
        int          count;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            issue(DIRECTED_ROWS[i].cmd, 1'b0, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        settle();

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:       seed = 32'h0000_0000;
                1:       seed = 32'hFFFF_FFFF;
                default: seed = $urandom;
            endcase
            write_seed(seed);
            count = (p < 2) ? 30 : 520;
            for (int n = 0; n < count; n++)
            begin
                if (n == 0)
                begin
                    c = random_command(1'b0, 100);
                    c.action = ACT_RESEED;
                end
                else
                    c = random_command(p < 2, (p < 2) ? 55 : 80);
                // hold off once mid-stream until the block has drained
                if (p == 2 && n == 450)
                    settle();
                issue(c, p == 2 && n >= 100 && n < 300, 1'b0, '0);
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
